// ===== src/spp_pkg.sv =====
package spp_pkg;

  localparam int DEG_ONE = 65536;
  localparam int DEG_90 = 90 * DEG_ONE;
  localparam int DEG_180 = 180 * DEG_ONE;
  localparam int DEG_360 = 360 * DEG_ONE;
  localparam int CORDIC_X0 = 652032874;
  localparam int ATAN_ENTRIES = 24;
  localparam int OUT_W = 26;
  localparam int REM_W = 11;

  typedef logic signed [31:0] cq_t;
  typedef logic signed [24:0] ang_t;
  typedef logic signed [OUT_W-1:0] pos_t;

  typedef enum logic [2:0] {
    REG_PITCH_X = 3'd0,
    REG_PITCH_Y = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_FPV = 3'd4,
    REG_ANGLE = 3'd5,
    REG_RADIUS = 3'd6,
    REG_UNUSED = 3'd7
  } reg_idx_t;

  function automatic logic [21:0] atan_deg(input int i);
    logic [21:0] v;
    unique case (i)
      0: v = 22'd2949120;
      1: v = 22'd1740967;
      2: v = 22'd919879;
      3: v = 22'd466945;
      4: v = 22'd234379;
      5: v = 22'd117304;
      6: v = 22'd58666;
      7: v = 22'd29335;
      8: v = 22'd14668;
      9: v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic pos_t sat_pos(input logic signed [27:0] v);
    pos_t r;
    if (v > 28'sd33554431) begin
      r = 26'sd33554431;
    end else if (v < -28'sd33554432) begin
      r = -26'sd33554432;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/spp_if.sv =====
interface spp_in_if;
  logic valid;
  logic ready;
  logic [31:0] frame_number;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  modport source(output valid, frame_number, pixel_x, pixel_y, input ready);
  modport sink(input valid, frame_number, pixel_x, pixel_y, output ready);
endinterface

interface spp_out_if;
  logic valid;
  logic ready;
  logic signed [25:0] pos_x;
  logic signed [25:0] pos_y;
  logic signed [25:0] pos_z;
  modport source(output valid, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== src/spp_div_cell.sv =====
module spp_div_cell #(
  parameter int IDX = 0,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [spp_pkg::REM_W-1:0] dvs,
  input  logic                     in_vld,
  input  logic [31:0]              in_num,
  input  logic [spp_pkg::REM_W-1:0] in_rem,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_vld,
  output logic [31:0]              out_num,
  output logic [spp_pkg::REM_W-1:0] out_rem,
  output logic [SIDE_W-1:0]        out_side
);
  import spp_pkg::*;

  localparam int BIT = 31 - IDX;

  logic [REM_W:0] t;
  logic [REM_W:0] d_ext;
  logic [REM_W-1:0] rem_nxt;

  assign t = {in_rem, in_num[BIT]};
  assign d_ext = {1'b0, dvs};
  assign rem_nxt = (t >= d_ext) ? REM_W'(t - d_ext) : t[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_num <= in_num;
      out_rem <= rem_nxt;
      out_side <= in_side;
    end
  end

endmodule

// ===== src/spp_cordic_cell.sv =====
module spp_cordic_cell #(
  parameter int IDX = 0,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  spp_pkg::cq_t        in_x,
  input  spp_pkg::cq_t        in_y,
  input  spp_pkg::ang_t       in_z,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output spp_pkg::cq_t        out_x,
  output spp_pkg::cq_t        out_y,
  output spp_pkg::ang_t       out_z,
  output logic [SIDE_W-1:0]   out_side
);
  import spp_pkg::*;

  localparam ang_t ATAN = ang_t'(atan_deg(IDX));

  cq_t dx;
  cq_t dy;

  assign dx = in_y >>> IDX;
  assign dy = in_x >>> IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_side <= in_side;
      if (in_z >= 0) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ATAN;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ATAN;
      end
    end
  end

endmodule

// ===== src/sweep_probe_pixel_to_3d.sv =====
// Pixel to 3D point mapper for a sweeping motorized probe. One pixel
// transaction is accepted per clock while the output is not held, and each
// gives one point (pos_x, pos_y, pos_z in micrometers) after the bit-serial
// chain of remainder cells that folds the frame number into the sweep, the
// registers of angle scaling and range reduction, the chain of rotation
// cells, and the registers for the radius products and rounding. When the
// output is held the whole pipeline holds with it. The user must see that
// registers are written only while no transaction is in flight; the block does not enforce this.
module sweep_probe_pixel_to_3d #(
  parameter int PIXEL_BITS = 12,
  parameter int TRIG_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  spp_in_if.sink      in_ch,
  spp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import spp_pkg::*;

  localparam int PB = (PIXEL_BITS < 12) ? PIXEL_BITS : 12;
  localparam int SD = 2 * PB;
  localparam int SC = 2 * PB + 1;
  localparam logic signed [25:0] A90 = 26'(DEG_90);
  localparam logic signed [25:0] A180 = 26'(DEG_180);
  localparam logic signed [25:0] A360 = 26'(DEG_360);

  logic [11:0] pitch_x_r, pitch_y_r, origin_x_r, origin_y_r;
  logic [9:0]  fpv_r;
  logic [19:0] apf_r;
  logic [17:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_x_r <= 12'd100;
      pitch_y_r <= 12'd100;
      origin_x_r <= 12'd0;
      origin_y_r <= 12'd0;
      fpv_r <= 10'd31;
      apf_r <= 20'd65536;
      radius_r <= 18'd0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PITCH_X: pitch_x_r <= cfg_data[11:0];
        REG_PITCH_Y: pitch_y_r <= cfg_data[11:0];
        REG_ORIGIN_X: origin_x_r <= cfg_data[11:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_data[11:0];
        REG_FPV: fpv_r <= cfg_data[9:0];
        REG_ANGLE: apf_r <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_vld_r;
  pos_t pos_x_r, pos_y_r, pos_z_r;

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_vld_r;
  assign out_ch.pos_x = pos_x_r;
  assign out_ch.pos_y = pos_y_r;
  assign out_ch.pos_z = pos_z_r;

  logic [9:0] fpv_e;
  logic [9:0] mid;
  logic [REM_W-1:0] dvs;

  assign fpv_e = (fpv_r == 10'd0) ? 10'd1 : fpv_r;
  assign mid = 10'((11'(fpv_e) + 11'd1) >> 1);
  assign dvs = {fpv_e, 1'b0};

  // frame number remainder chain
  logic             dv_vld  [0:32];
  logic [31:0]      dv_num  [0:32];
  logic [REM_W-1:0] dv_rem  [0:32];
  logic [SD-1:0]    dv_side [0:32];

  assign dv_vld[0] = in_ch.valid;
  assign dv_num[0] = in_ch.frame_number;
  assign dv_rem[0] = '0;
  assign dv_side[0] = {in_ch.pixel_x[PB-1:0], in_ch.pixel_y[PB-1:0]};

  for (genvar g = 0; g < 32; g++) begin : g_div
    spp_div_cell #(.IDX(g), .SIDE_W(SD)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .dvs(dvs),
      .in_vld(dv_vld[g]), .in_num(dv_num[g]), .in_rem(dv_rem[g]), .in_side(dv_side[g]),
      .out_vld(dv_vld[g+1]), .out_num(dv_num[g+1]), .out_rem(dv_rem[g+1]),
      .out_side(dv_side[g+1])
    );
  end

  // signed frame offset times angle step
  logic signed [11:0] k;
  logic signed [32:0] prod;
  logic               kp_vld_r;
  logic signed [32:0] kp_prod_r;
  logic [SD-1:0]      kp_side_r;

  always_comb begin
    if (dv_rem[32] < {1'b0, fpv_e}) begin
      k = $signed({1'b0, dv_rem[32]}) - $signed({2'b0, mid});
    end else begin
      k = $signed({2'b0, mid}) - ($signed({1'b0, dv_rem[32]}) - $signed({2'b0, fpv_e}));
    end
    prod = 33'(k) * 33'($signed({1'b0, apf_r}));
  end

  // magnitude and reduction by multiples of a full turn
  logic             rd_vld  [0:6];
  logic [29:0]      rd_m    [0:6];
  logic             rd_neg  [0:6];
  logic [SD-1:0]    rd_side [0:6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_vld_r <= 1'b0;
      rd_vld[0] <= 1'b0;
    end else if (adv) begin
      kp_vld_r <= dv_vld[32];
      rd_vld[0] <= kp_vld_r;
    end
    if (adv) begin
      kp_prod_r <= prod;
      kp_side_r <= dv_side[32];
      rd_neg[0] <= kp_prod_r < 0;
      rd_m[0] <= (kp_prod_r < 0) ? 30'(-kp_prod_r) : 30'(kp_prod_r);
      rd_side[0] <= kp_side_r;
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_red
    localparam logic [29:0] SUB = 30'(DEG_360) << (5 - j);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rd_vld[j+1] <= 1'b0;
      end else if (adv) begin
        rd_vld[j+1] <= rd_vld[j];
      end
      if (adv) begin
        rd_m[j+1] <= (rd_m[j] >= SUB) ? rd_m[j] - SUB : rd_m[j];
        rd_neg[j+1] <= rd_neg[j];
        rd_side[j+1] <= rd_side[j];
      end
    end
  end

  // wrap into a half turn either side, then fold into the right half plane
  logic signed [25:0] sa;
  logic signed [25:0] wa;
  logic               wr_vld_r;
  logic signed [25:0] wr_a_r;
  logic [SD-1:0]      wr_side_r;
  logic               fd_vld_r;
  ang_t               fd_z_r;
  logic               fd_neg_r;
  logic [SD-1:0]      fd_side_r;
  ang_t               fz;
  logic               fneg;

  always_comb begin
    sa = rd_neg[6] ? -$signed({1'b0, rd_m[6][24:0]}) : $signed({1'b0, rd_m[6][24:0]});
    if (sa >= A180) begin
      wa = sa - A360;
    end else if (sa < -A180) begin
      wa = sa + A360;
    end else begin
      wa = sa;
    end
    if (wr_a_r > A90) begin
      fz = 25'(wr_a_r - A180);
      fneg = 1'b1;
    end else if (wr_a_r < -A90) begin
      fz = 25'(wr_a_r + A180);
      fneg = 1'b1;
    end else begin
      fz = 25'(wr_a_r);
      fneg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
      fd_vld_r <= 1'b0;
    end else if (adv) begin
      wr_vld_r <= rd_vld[6];
      fd_vld_r <= wr_vld_r;
    end
    if (adv) begin
      wr_a_r <= wa;
      wr_side_r <= rd_side[6];
      fd_z_r <= fz;
      fd_neg_r <= fneg;
      fd_side_r <= wr_side_r;
    end
  end

  // rotation chain
  logic          cr_vld  [0:TRIG_STAGES];
  cq_t           cr_x    [0:TRIG_STAGES];
  cq_t           cr_y    [0:TRIG_STAGES];
  ang_t          cr_z    [0:TRIG_STAGES];
  logic [SC-1:0] cr_side [0:TRIG_STAGES];

  assign cr_vld[0] = fd_vld_r;
  assign cr_x[0] = cq_t'(CORDIC_X0);
  assign cr_y[0] = '0;
  assign cr_z[0] = fd_z_r;
  assign cr_side[0] = {fd_neg_r, fd_side_r};

  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_rot
    spp_cordic_cell #(.IDX(g), .SIDE_W(SC)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_vld(cr_vld[g]), .in_x(cr_x[g]), .in_y(cr_y[g]), .in_z(cr_z[g]),
      .in_side(cr_side[g]),
      .out_vld(cr_vld[g+1]), .out_x(cr_x[g+1]), .out_y(cr_y[g+1]), .out_z(cr_z[g+1]),
      .out_side(cr_side[g+1])
    );
  end

  // radius, lateral offset and signed trig
  logic          ce_neg;
  logic [PB-1:0] ce_px, ce_py;
  logic signed [12:0] dxp, dyp;
  logic signed [25:0] r_c, posx_c;

  assign ce_neg = cr_side[TRIG_STAGES][SC-1];
  assign ce_px = cr_side[TRIG_STAGES][SD-1:PB];
  assign ce_py = cr_side[TRIG_STAGES][PB-1:0];
  assign dxp = $signed({1'b0, 12'(ce_px)}) - $signed({1'b0, origin_x_r});
  assign dyp = $signed({1'b0, 12'(ce_py)}) - $signed({1'b0, origin_y_r});
  assign r_c = 26'(dyp) * 26'($signed({1'b0, pitch_y_r})) + $signed({8'b0, radius_r});
  assign posx_c = -(26'(dxp) * 26'($signed({1'b0, pitch_x_r})));

  logic               m0_vld_r;
  logic signed [25:0] m0_r_r, m0_px_r;
  cq_t                m0_c_r, m0_s_r;
  logic               m1_vld_r;
  logic signed [42:0] m1_ch_r, m1_cl_r, m1_sh_r, m1_sl_r;
  logic signed [25:0] m1_px_r;
  logic signed [57:0] sum_c, sum_s;
  logic signed [57:0] q_c, q_s;

  always_comb begin
    sum_c = (58'(m1_ch_r) <<< 16) + 58'(m1_cl_r) + (58'sd1 <<< 29);
    sum_s = (58'(m1_sh_r) <<< 16) + 58'(m1_sl_r) + (58'sd1 <<< 29);
    q_c = sum_c >>> 30;
    q_s = sum_s >>> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_vld_r <= 1'b0;
      m1_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      m0_vld_r <= cr_vld[TRIG_STAGES];
      m1_vld_r <= m0_vld_r;
      out_vld_r <= m1_vld_r;
    end
    if (adv) begin
      m0_r_r <= r_c;
      m0_px_r <= posx_c;
      m0_c_r <= ce_neg ? -cr_x[TRIG_STAGES] : cr_x[TRIG_STAGES];
      m0_s_r <= ce_neg ? -cr_y[TRIG_STAGES] : cr_y[TRIG_STAGES];
      m1_ch_r <= 43'(m0_r_r) * 43'($signed(m0_c_r[31:16]));
      m1_cl_r <= 43'(m0_r_r) * 43'($signed({1'b0, m0_c_r[15:0]}));
      m1_sh_r <= 43'(m0_r_r) * 43'($signed(m0_s_r[31:16]));
      m1_sl_r <= 43'(m0_r_r) * 43'($signed({1'b0, m0_s_r[15:0]}));
      m1_px_r <= m0_px_r;
      pos_x_r <= m1_px_r;
      pos_y_r <= sat_pos($signed(q_c[27:0]));
      pos_z_r <= sat_pos($signed(q_s[27:0]));
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[32] |-> dv_rem[32] < dvs)
    else $error("sweep position not below divisor");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_vld_r |-> (wr_a_r >= -A180 && wr_a_r < A180))
    else $error("wrapped angle out of range");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    fd_vld_r |-> (fd_z_r <= 25'(A90) && fd_z_r >= -25'(A90)))
    else $error("folded angle out of range");
`endif

endmodule
